// ----- rtl/scds_pkg.sv -----
// Shared types and constants for the site colour density shader.
`default_nettype none

package scds_pkg;

  localparam int unsigned SiteW   = 12;
  localparam int unsigned DensW   = 17;
  localparam int unsigned ChanW   = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 17;
  localparam int unsigned FactorW = 18;
  localparam int unsigned FracW   = 14;

  // Register reset values
  localparam logic [15:0] SaturationRst = 16'd52429;
  localparam logic [15:0] ValueRst      = 16'd60293;
  localparam logic [16:0] HueStepRst    = 17'd35202;
  localparam logic [16:0] DensFloorRst  = 17'd29491;
  localparam logic [16:0] DensGainRst   = 17'd36045;

  localparam logic [DensW-1:0] DensOne   = 17'd65536;
  localparam logic [FracW-1:0] HueSector = 14'd15360;

  // ceil(2^24 / 45): exact quotient for any 18-bit dividend
  localparam logic [18:0] Mod45Recip = 19'd372828;
  // ceil(2^24 / 15): exact quotient for any 20-bit dividend
  localparam logic [20:0] Div15Recip = 21'd1118482;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSaturation = 3'd0,
    CfgValue      = 3'd1,
    CfgHueStep    = 3'd2,
    CfgDensFloor  = 3'd3,
    CfgDensGain   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SecRedYellow   = 3'd0,
    SecYellowGreen = 3'd1,
    SecGreenCyan   = 3'd2,
    SecCyanBlue    = 3'd3,
    SecBlueMagenta = 3'd4,
    SecMagentaRed  = 3'd5
  } sector_e;

  typedef struct packed {
    logic [15:0] saturation;
    logic [15:0] value;
    logic [16:0] hue_step;
    logic [16:0] dens_floor;
    logic [16:0] dens_gain;
  } cfg_t;

  typedef struct packed {
    sector_e            sector;
    logic [FracW-1:0]   frac;
    logic [15:0]        chroma;
    logic [15:0]        offset;
    logic [FactorW-1:0] factor;
  } hue_t;

  typedef struct packed {
    logic [ChanW-1:0]   red;
    logic [ChanW-1:0]   green;
    logic [ChanW-1:0]   blue;
    logic [FactorW-1:0] factor;
  } base_t;

endpackage

`default_nettype wire

// ----- rtl/site_colour_density_shader_core.sv -----
// Top level of the site colour density shader.
`default_nettype none

// Shades one pixel per clock, taking a new request every cycle, when the output
// is not stalled: the site index sets a hue of index times hue_step mod 360
// degrees, which is turned into RGB with the configured saturation and value
// and then scaled by density_floor + density_gain * density (density saturates
// at 1.0). The datapath is seven register stages with a valid bit each; each
// stage is at most one multiplier deep, so the stage count sets the latency.
// A stall on the output holds the full pipeline, while empty stages keep
// filling. Configuration is written through a plain write port; the user must
// write it only while the pipe is empty, as the block does not enforce this.
module site_colour_density_shader_core import scds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SiteW-1:0]    site_index_i,
  input  logic [DensW-1:0]    density_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ChanW-1:0]    red_o,
  output logic [ChanW-1:0]    green_o,
  output logic [ChanW-1:0]    blue_o
);

  cfg_t  cfg;
  hue_t  hue;
  base_t base;
  logic  hue_ready, hue_valid;
  logic  chroma_ready, chroma_valid;
  logic  scale_ready;

  scds_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  scds_hue u_hue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (hue_ready),
    .site_index_i (site_index_i),
    .density_i    (density_i),
    .out_valid_o  (hue_valid),
    .out_ready_i  (chroma_ready),
    .out_o        (hue)
  );

  scds_chroma u_chroma (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hue_valid),
    .in_ready_o  (chroma_ready),
    .in_i        (hue),
    .out_valid_o (chroma_valid),
    .out_ready_i (scale_ready),
    .out_o       (base)
  );

  scds_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chroma_valid),
    .in_ready_o  (scale_ready),
    .in_i        (base),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  assign in_stall_o = !hue_ready;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && hue_valid && chroma_valid))
    else $error("input stalled while the pipeline can still advance");
`endif

endmodule

`default_nettype wire

// ----- rtl/scds_cfg.sv -----
// Configuration register file for the shader.
`default_nettype none

module scds_cfg import scds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.saturation <= SaturationRst;
      cfg_q.value      <= ValueRst;
      cfg_q.hue_step   <= HueStepRst;
      cfg_q.dens_floor <= DensFloorRst;
      cfg_q.dens_gain  <= DensGainRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSaturation: cfg_q.saturation <= cfg_data_i[15:0];
        CfgValue:      cfg_q.value      <= cfg_data_i[15:0];
        CfgHueStep:    cfg_q.hue_step   <= cfg_data_i;
        CfgDensFloor:  cfg_q.dens_floor <= cfg_data_i;
        CfgDensGain:   cfg_q.dens_gain  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/scds_hue.sv -----
// Hue stages: site times step mod 360 degrees, sector split, chroma and brightness factor.
`default_nettype none

module scds_hue import scds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [SiteW-1:0] site_index_i,
  input  logic [DensW-1:0] density_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hue_t             out_o
);

  logic [2:0] valid_q;
  logic [2:0] en;

  assign en[2] = !valid_q[2] || out_ready_i;
  assign en[1] = !valid_q[1] || en[2];
  assign en[0] = !valid_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  // Stage 1: raw hue product, density gain product, V*S
  logic [DensW-1:0] dens_sat;
  logic [28:0]      hprod_d, hprod_q;
  logic [33:0]      gprod_d, gprod_q;
  logic [31:0]      vs_d, vs_q;
  logic [15:0]      val_q;

  assign dens_sat = (density_i > DensOne) ? DensOne : density_i;
  assign hprod_d  = {17'b0, site_index_i} * {12'b0, cfg_i.hue_step};
  assign gprod_d  = {17'b0, dens_sat} * {17'b0, cfg_i.dens_gain};
  assign vs_d     = {16'b0, cfg_i.value} * {16'b0, cfg_i.saturation};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hprod_q <= hprod_d;
      gprod_q <= gprod_d;
      vs_q    <= vs_d;
      val_q   <= cfg_i.value;
    end
  end

  // Stage 2: 92160 = 2048 * 45, so take the upper bits mod 45 by reciprocal
  logic [17:0]        hi_d, hi_q;
  logic [10:0]        low_q;
  logic [36:0]        qprod_d, qprod_q;
  logic [FactorW-1:0] factor_d, factor_q;
  logic [15:0]        chroma_q, offset_q;

  assign hi_d     = hprod_q[28:11];
  assign qprod_d  = {19'b0, hi_d} * {18'b0, Mod45Recip};
  assign factor_d = {1'b0, cfg_i.dens_floor} + {1'b0, gprod_q[32:16]};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      hi_q     <= hi_d;
      low_q    <= hprod_q[10:0];
      qprod_q  <= qprod_d;
      factor_q <= factor_d;
      chroma_q <= vs_q[31:16];
      offset_q <= val_q - vs_q[31:16];
    end
  end

  // Stage 3: remainder, then sector and fraction within the sector
  logic [12:0]      quot;
  logic [17:0]      rem_full;
  logic [6:0]       tens;
  sector_e          sector;
  logic [6:0]       sec_base;
  logic [6:0]       sec_rem;
  logic [FracW-1:0] frac;
  hue_t             out_d, out_q;

  assign quot     = qprod_q[36:24];
  assign rem_full = hi_q - ({5'b0, quot} * 18'd45);
  // hue >> 10, in units of 1024 Q9.8 steps; one sector is 15 of them
  assign tens     = {rem_full[5:0], low_q[10]};

  always_comb begin
    if (tens >= 7'd75) begin
      sector = SecMagentaRed;  sec_base = 7'd75;
    end else if (tens >= 7'd60) begin
      sector = SecBlueMagenta; sec_base = 7'd60;
    end else if (tens >= 7'd45) begin
      sector = SecCyanBlue;    sec_base = 7'd45;
    end else if (tens >= 7'd30) begin
      sector = SecGreenCyan;   sec_base = 7'd30;
    end else if (tens >= 7'd15) begin
      sector = SecYellowGreen; sec_base = 7'd15;
    end else begin
      sector = SecRedYellow;   sec_base = 7'd0;
    end
  end

  assign sec_rem = tens - sec_base;
  assign frac    = {sec_rem[3:0], low_q[9:0]};

  always_comb begin
    out_d.sector = sector;
    out_d.frac   = sector[0] ? (HueSector - frac) : frac;
    out_d.chroma = chroma_q;
    out_d.offset = offset_q;
    out_d.factor = factor_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) out_q <= out_d;
  end

  assign out_valid_o = valid_q[2];
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_frac_in_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[2] |-> (out_q.frac <= HueSector))
    else $error("sector fraction exceeds one sector");
`endif

endmodule

`default_nettype wire

// ----- rtl/scds_chroma.sv -----
// Chroma stages: secondary component X and the three 8-bit base channels.
`default_nettype none

module scds_chroma import scds_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  hue_t  in_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output base_t out_o
);

  function automatic logic [ChanW-1:0] to_chan(logic [15:0] comp, logic [15:0] off);
    logic [16:0] sum;
    logic [24:0] prod;
    sum  = {1'b0, comp} + {1'b0, off};
    prod = {sum, 8'b0} - {8'b0, sum};
    return prod[23:16];
  endfunction

  logic [2:0] valid_q;
  logic [2:0] en;

  assign en[2] = !valid_q[2] || out_ready_i;
  assign en[1] = !valid_q[1] || en[2];
  assign en[0] = !valid_q[0] || en[1];
  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
      if (en[2]) valid_q[2] <= valid_q[1];
    end
  end

  // Stage 1: C times fraction
  hue_t        h1_q, h2_q;
  logic [29:0] xprod_d, xprod_q;

  assign xprod_d = {14'b0, in_i.chroma} * {16'b0, in_i.frac};

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      h1_q    <= in_i;
      xprod_q <= xprod_d;
    end
  end

  // Stage 2: divide by 15360 = 1024 * 15 through the reciprocal of 15
  logic [19:0] xdiv;
  logic [40:0] xq_d, xq_q;

  assign xdiv = xprod_q[29:10];
  assign xq_d = {21'b0, xdiv} * {20'b0, Div15Recip};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      h2_q <= h1_q;
      xq_q <= xq_d;
    end
  end

  // Stage 3: route C and X by sector, add m, scale to 8 bits
  logic [15:0] xval;
  logic [15:0] rr, gg, bb;
  base_t       out_d, out_q;

  assign xval = xq_q[39:24];

  always_comb begin
    case (h2_q.sector)
      SecRedYellow: begin
        rr = h2_q.chroma; gg = xval;        bb = '0;
      end
      SecYellowGreen: begin
        rr = xval;        gg = h2_q.chroma; bb = '0;
      end
      SecGreenCyan: begin
        rr = '0;          gg = h2_q.chroma; bb = xval;
      end
      SecCyanBlue: begin
        rr = '0;          gg = xval;        bb = h2_q.chroma;
      end
      SecBlueMagenta: begin
        rr = xval;        gg = '0;          bb = h2_q.chroma;
      end
      default: begin
        rr = h2_q.chroma; gg = '0;          bb = xval;
      end
    endcase
  end

  always_comb begin
    out_d.red    = to_chan(rr, h2_q.offset);
    out_d.green  = to_chan(gg, h2_q.offset);
    out_d.blue   = to_chan(bb, h2_q.offset);
    out_d.factor = h2_q.factor;
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) out_q <= out_d;
  end

  assign out_valid_o = valid_q[2];
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_x_below_chroma: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> (!xq_q[40] && (xq_q[39:24] <= h2_q.chroma)))
    else $error("secondary component exceeds chroma");
`endif

endmodule

`default_nettype wire

// ----- rtl/scds_scale.sv -----
// Output stage: density brightness scaling with saturation to 255.
`default_nettype none

module scds_scale import scds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  base_t            in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ChanW-1:0] red_o,
  output logic [ChanW-1:0] green_o,
  output logic [ChanW-1:0] blue_o
);

  function automatic logic [ChanW-1:0] scale_chan(logic [ChanW-1:0] base,
                                                  logic [FactorW-1:0] factor);
    logic [25:0] prod;
    prod = {18'b0, base} * {8'b0, factor};
    return (prod[25:24] != 2'b00) ? 8'hFF : prod[23:16];
  endfunction

  logic             valid_q;
  logic             en;
  logic [ChanW-1:0] red_q, green_q, blue_q;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= scale_chan(in_i.red, in_i.factor);
      green_q <= scale_chan(in_i.green, in_i.factor);
      blue_q  <= scale_chan(in_i.blue, in_i.factor);
    end
  end

  assign out_valid_o = valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

`default_nettype wire
